// File: sv/stq_pkg.sv
// Shared types and constants for the sorted timeout queue.
package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;

    localparam int DL_W    = 32;
    localparam int ID_W    = 8;
    localparam int ARG_W   = 32;
    localparam int DELAY_W = 24;

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic STATUS_EXPIRED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [ID_W-1:0]  id;
        logic [ARG_W-1:0] arg;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJ,
        ST_AR_CHK,
        ST_AR_CMP,
        ST_SH_CHK,
        ST_SH_WR,
        ST_AR_WR,
        ST_TK_CHK,
        ST_TK_CMP,
        ST_TK_FIN
    } state_t;

endpackage

// File: sv/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/sorted_timeout_queue_top.sv
// Sorted timeout queue: circular buffer in RAM, one shared deadline comparator.
// Arm: rejected if full, else find the slot, shift later entries up, write (one RAM port).
// Tick: examines entries from the head, stopping at a later one, at queue end or at limit.
// Any state that loads the output register waits while the output stalls.
// One transaction at a time; results wait in an output register so input is taken meanwhile.
// Reset (rst_n low, async): tick count zero, queue empty; RAM contents are not cleared.
module sorted_timeout_queue_top
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // delay_ticks[23:0], callback_id[31:24], callback_arg[63:32]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // expired_id[7:0], expired_arg[39:8]
    output logic        m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // logical offset from head to physical RAM address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(ofs);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [DL_W-1:0]   tick_reg, tick_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ARG_W-1:0]  arg_reg, arg_next;
    entry_t            pend_reg, pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [ARG_W-1:0]  out_arg_reg, out_arg_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    logic              out_free;
    logic [DL_W-1:0]   cmp_ref;
    logic [DL_W-1:0]   cmp_diff;
    logic              is_later;

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_axis_tready;

    // shared comparator: stored deadline strictly later than reference (signed diff)
    assign cmp_ref  = (state_reg == ST_TK_CMP) ? tick_reg : dl_reg;
    assign cmp_diff = ram_rdata.deadline - cmp_ref;
    assign is_later = (cmp_diff != '0) && !cmp_diff[DL_W-1];

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        tick_next       = tick_reg;
        dl_next         = dl_reg;
        id_next         = id_reg;
        arg_next        = arg_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_id_next     = out_id_reg;
        out_arg_next    = out_arg_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    id_next  = s_axis_tdata[31:24];
                    arg_next = s_axis_tdata[63:32];
                    idx_next = '0;
                    if (s_axis_tuser == CMD_TICK)
                    begin
                        tick_next  = tick_reg + DL_W'(1);
                        state_next = ST_TK_CHK;
                    end
                    else if (occ_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        state_next = ST_REJ;
                    end
                    else
                    begin
                        dl_next    = tick_reg + DL_W'(s_axis_tdata[DELAY_W-1:0]);
                        state_next = ST_AR_CHK;
                    end
                end
            end

            ST_REJ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = id_reg;
                    out_arg_next    = arg_reg;
                    out_status_next = STATUS_REJECTED;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_AR_CHK:
            begin
                if (idx_reg < occ_reg)
                begin
                    state_next = ST_AR_CMP;
                end
                else
                begin
                    pos_next   = idx_reg;
                    idx_next   = occ_reg;
                    state_next = ST_SH_CHK;
                end
            end

            ST_AR_CMP:
            begin
                if (is_later)
                begin
                    pos_next   = idx_reg;
                    idx_next   = occ_reg;
                    state_next = ST_SH_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_AR_CHK;
                end
            end

            ST_SH_CHK:
            begin
                state_next = (idx_reg > pos_reg) ? ST_SH_WR : ST_AR_WR;
            end

            ST_SH_WR:
            begin
                idx_next   = idx_reg - CNT_W'(1);
                state_next = ST_SH_CHK;
            end

            ST_AR_WR:
            begin
                occ_next   = occ_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end

            ST_TK_CHK:
            begin
                if ((idx_reg < occ_reg) && (int'(idx_reg) < MAX_RESULTS))
                begin
                    state_next = ST_TK_CMP;
                end
                else
                begin
                    state_next = ST_TK_FIN;
                end
            end

            ST_TK_CMP:
            begin
                if (is_later)
                begin
                    state_next = ST_TK_FIN;
                end
                else if (idx_reg == '0)
                begin
                    pend_next  = ram_rdata;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_TK_CHK;
                end
                else if (out_free)
                begin
                    // another due entry follows, so the held one is not last
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_reg.id;
                    out_arg_next    = pend_reg.arg;
                    out_status_next = STATUS_EXPIRED;
                    out_last_next   = 1'b0;
                    pend_next       = ram_rdata;
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = ST_TK_CHK;
                end
            end

            ST_TK_FIN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_reg.id;
                    out_arg_next    = pend_reg.arg;
                    out_status_next = STATUS_EXPIRED;
                    out_last_next   = 1'b1;
                    head_next       = phys(head_reg, idx_reg);
                    occ_next        = occ_reg - idx_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM control and handshake outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = ram_rdata;
        ram_raddr     = '0;

        case (state_reg)
            ST_AR_CHK:
            begin
                ram_raddr = phys(head_reg, idx_reg);
            end

            ST_SH_CHK:
            begin
                ram_raddr = phys(head_reg, idx_reg - CNT_W'(1));
            end

            ST_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, idx_reg);
                ram_wdata = ram_rdata;
            end

            ST_AR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, pos_reg);
                ram_wdata = '{deadline: dl_reg, id: id_reg, arg: arg_reg};
            end

            ST_TK_CHK, ST_TK_CMP:
            begin
                // re-read in TK_CMP keeps the data steady while the output stalls
                ram_raddr = phys(head_reg, idx_reg);
            end

            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_arg_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg         <= dl_next;
        id_reg         <= id_next;
        arg_reg        <= arg_next;
        pend_reg       <= pend_next;
        out_id_reg     <= out_id_next;
        out_arg_reg    <= out_arg_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REJ) |-> (occ_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("arm rejected while queue not full");

    a_arm_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AR_WR) |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow occupancy by one");

    a_tick_take: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_TK_CHK) || (state_reg == ST_TK_FIN)) |->
            ((idx_reg <= occ_reg) && (int'(idx_reg) <= MAX_RESULTS)))
        else $error("tick removal count out of range");

endmodule
